// ===== sv/dbc_pkg.sv =====
// shared types, constants and helper functions of the dither and braille cell encoder
// no dependencies; imported by every module of the block except dbc_ram
package dbc_pkg;

  localparam int unsigned MaxWidthDef  = 128;
  localparam int unsigned MaxHeightDef = 128;

  // configuration reset values
  localparam logic [7:0] WidthRst  = 8'd128;
  localparam logic [7:0] HeightRst = 8'd128;
  localparam logic [7:0] PassRst   = 8'd16;

  // register indexes on the configuration port
  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegPass   = 2'd2;

  // input commands
  localparam logic [1:0] CmdLoad = 2'd0;
  localparam logic [1:0] CmdRun  = 2'd1;
  localparam logic [1:0] CmdRead = 2'd2;

  // diffusion taps
  localparam logic [2:0] TapCentre = 3'd0;
  localparam logic [2:0] TapUp     = 3'd1;
  localparam logic [2:0] TapDown   = 3'd2;
  localparam logic [2:0] TapLeft   = 3'd3;
  localparam logic [2:0] TapRight  = 3'd4;
  localparam logic [2:0] TapLastDf = TapRight;
  localparam logic [2:0] TapLastCe = 3'd7;

  localparam logic [7:0]  DotLevel    = 8'h80;
  localparam logic [13:0] BrailleBase = 14'h2800;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load_wr;
    logic       lad_clr;
    logic       xy_clr;
    logic       xy_inc;
    logic       pass_clr;
    logic       pass_inc;
    logic       cp_rd;
    logic       df_rd;
    logic       df_wr;
    logic       ce_rd;
    logic       cell_ld;
    logic       out_ld;
    logic [2:0] tap;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic xy_last;
    logic pass_done;
    logic thin;
    logic out_busy;
  } dp_sts_t;

  // share sent to each neighbour: spread / 6 truncated toward zero
  function automatic logic signed [5:0] share_of(input logic [7:0] p);
    logic signed [8:0] spread;
    logic [6:0]        mag;
    logic [12:0]       prod;
    logic [5:0]        q;
    spread = (p > 8'd40) ? (9'sd128 - $signed({1'b0, p}))
                         : (9'sd32 - $signed({1'b0, p}));
    mag  = spread[8] ? 7'(-spread) : spread[6:0];
    // reciprocal of six, exact for magnitudes below 128
    prod = 13'(mag) * 13'd43;
    q    = 6'(prod >> 8);
    share_of = spread[8] ? -$signed(q) : $signed(q);
  endfunction

  // column offset of dot k in a cell
  function automatic logic cell_dx(input logic [2:0] k);
    case (k)
      3'd3, 3'd4, 3'd5, 3'd7: cell_dx = 1'b1;
      default:                cell_dx = 1'b0;
    endcase
  endfunction

  // row offset of dot k in a cell
  function automatic logic [1:0] cell_dy(input logic [2:0] k);
    case (k)
      3'd1, 3'd4: cell_dy = 2'd1;
      3'd2, 3'd5: cell_dy = 2'd2;
      3'd6, 3'd7: cell_dy = 2'd3;
      default:    cell_dy = 2'd0;
    endcase
  endfunction

endpackage

// ===== sv/dbc_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module dbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dbc_ctrl.sv =====
// controller state machine: sequences loads, copy and diffusion passes, cell reads
// depends on dbc_pkg
module dbc_ctrl
  import dbc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_cmd_i,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StIdle,
    StPassChk,
    StCopy,
    StCopyEnd,
    StDfRd,
    StDfLast,
    StDfWr,
    StCeRd,
    StCeLast,
    StCeOut
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] tap_q, tap_d;

  assign in_ready_o = (state_q == StIdle);

  // next state and command decode
  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    cmd_o   = '0;
    cmd_o.tap = tap_q;
    case (state_q)
      StIdle: begin
        tap_d = '0;
        if (in_valid_i) begin
          case (in_cmd_i)
            CmdLoad: cmd_o.load_wr = 1'b1;
            CmdRun: begin
              cmd_o.lad_clr  = 1'b1;
              cmd_o.pass_clr = 1'b1;
              cmd_o.xy_clr   = 1'b1;
              if (!sts_i.thin) begin
                state_d = StPassChk;
              end
            end
            CmdRead: begin
              cmd_o.cell_ld = 1'b1;
              state_d       = StCeRd;
            end
            default: ;
          endcase
        end
      end
      StPassChk: begin
        cmd_o.xy_clr = 1'b1;
        state_d = sts_i.pass_done ? StIdle : StCopy;
      end
      StCopy: begin
        cmd_o.cp_rd  = 1'b1;
        cmd_o.tap    = TapCentre;
        cmd_o.xy_inc = 1'b1;
        if (sts_i.xy_last) begin
          state_d = StCopyEnd;
        end
      end
      StCopyEnd: begin
        // lets the last scratch write land before diffusion reads
        cmd_o.xy_clr = 1'b1;
        tap_d   = TapCentre;
        state_d = StDfRd;
      end
      StDfRd: begin
        cmd_o.df_rd = 1'b1;
        tap_d = tap_q + 3'd1;
        if (tap_q == TapLastDf) begin
          state_d = StDfLast;
        end
      end
      StDfLast: state_d = StDfWr;
      StDfWr: begin
        cmd_o.df_wr  = 1'b1;
        cmd_o.tap    = TapCentre;
        cmd_o.xy_inc = 1'b1;
        tap_d = TapCentre;
        if (sts_i.xy_last) begin
          cmd_o.pass_inc = 1'b1;
          state_d = StPassChk;
        end else begin
          state_d = StDfRd;
        end
      end
      StCeRd: begin
        cmd_o.ce_rd = 1'b1;
        tap_d = tap_q + 3'd1;
        if (tap_q == TapLastCe) begin
          state_d = StCeLast;
        end
      end
      StCeLast: state_d = StCeOut;
      StCeOut: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_ld = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tap_q   <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
    end
  end

endmodule

// ===== sv/dbc_dp.sv =====
// datapath: counters, address generation, pixel and scratch memories, diffusion
// arithmetic, cell encoding and output register; depends on dbc_pkg and dbc_ram
module dbc_dp
  import dbc_pkg::*;
#(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [7:0]  pixel_i,
  input  logic [4:0]  cell_row_i,
  input  logic [5:0]  cell_col_i,
  input  logic [7:0]  width_i,
  input  logic [7:0]  height_i,
  input  logic [7:0]  pass_count_i,
  output dp_sts_t     sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] out_data_o,
  output logic        out_flag_o
);

  localparam int unsigned Depth = MaxWidth * MaxHeight;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned LAW   = $clog2(Depth + 1);
  localparam int unsigned PW    = (AW > 18) ? AW : 18;

  logic [7:0]        x_q, y_q;
  logic [7:0]        pass_q;
  logic [LAW-1:0]    lad_q;
  logic [4:0]        row_q;
  logic [5:0]        col_q;
  logic signed [10:0] acc_q;
  logic [7:0]        dots_q;
  logic              rv_q, rcell_q, rok_q;
  logic [2:0]        rtap_q;
  logic              cp_vld_q;
  logic [AW-1:0]     cp_addr_q;
  logic              ov_q;
  logic [7:0]        odots_q;
  logic              ooor_q;

  logic [15:0]       area;
  logic              lad_ok;
  logic [8:0]        nx, ny, dx, dy, cx, cy;
  logic [PW-1:0]     addr_full;
  logic [AW-1:0]     addr;
  logic              interior, inb, oor;
  logic [7:0]        st_rdata, sc_rdata;
  logic signed [5:0] shr, shr_m;
  logic signed [10:0] shr_x;
  logic [7:0]        clamped;

  assign area   = 16'(width_i) * 16'(height_i);
  assign lad_ok = 32'(lad_q) < 32'(area);

  // tap coordinates for diffusion and for the cell being read
  always_comb begin
    dx = {1'b0, x_q};
    dy = {1'b0, y_q};
    case (cmd_i.tap)
      TapUp:    dy = {1'b0, y_q} - 9'd1;
      TapDown:  dy = {1'b0, y_q} + 9'd1;
      TapLeft:  dx = {1'b0, x_q} - 9'd1;
      TapRight: dx = {1'b0, x_q} + 9'd1;
      default:  ;
    endcase
  end

  assign cx = {2'b0, col_q, 1'b0} + 9'(cell_dx(cmd_i.tap));
  assign cy = {2'b0, row_q, 2'b0} + 9'(cell_dy(cmd_i.tap));
  assign nx = cmd_i.ce_rd ? cx : dx;
  assign ny = cmd_i.ce_rd ? cy : dy;

  assign addr_full = PW'(ny) * PW'(width_i) + PW'(nx);
  assign addr      = addr_full[AW-1:0];

  // interior test for a sender, bounds test for a dot
  assign interior = (nx != 9'd0) && (ny != 9'd0) &&
                    ({1'b0, nx} + 10'd2 <= {2'b0, width_i}) &&
                    ({1'b0, ny} + 10'd2 <= {2'b0, height_i});
  assign inb      = (nx < {1'b0, width_i}) && (ny < {1'b0, height_i});

  // share of the pixel returned from scratch
  assign shr   = share_of(sc_rdata);
  assign shr_m = rok_q ? shr : 6'sd0;
  assign shr_x = 11'(shr_m);

  assign clamped = acc_q[10] ? 8'd0 : ((acc_q > 11'sd255) ? 8'd255 : acc_q[7:0]);

  dbc_ram #(.Width(8), .Depth(Depth)) u_store (
    .clk_i,
    .we_i    ((cmd_i.load_wr && lad_ok) || cmd_i.df_wr),
    .waddr_i (cmd_i.df_wr ? addr : lad_q[AW-1:0]),
    .wdata_i (cmd_i.df_wr ? clamped : pixel_i),
    .re_i    (cmd_i.cp_rd || cmd_i.ce_rd),
    .raddr_i (addr),
    .rdata_o (st_rdata)
  );

  dbc_ram #(.Width(8), .Depth(Depth)) u_scratch (
    .clk_i,
    .we_i    (cp_vld_q),
    .waddr_i (cp_addr_q),
    .wdata_i (st_rdata),
    .re_i    (cmd_i.df_rd),
    .raddr_i (addr),
    .rdata_o (sc_rdata)
  );

  // control counters and read tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      pass_q   <= '0;
      lad_q    <= '0;
      rv_q     <= 1'b0;
      cp_vld_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (cmd_i.xy_clr) begin
        x_q <= '0;
        y_q <= '0;
      end else if (cmd_i.xy_inc) begin
        if (x_q == width_i - 8'd1) begin
          x_q <= '0;
          y_q <= (y_q == height_i - 8'd1) ? 8'd0 : y_q + 8'd1;
        end else begin
          x_q <= x_q + 8'd1;
        end
      end
      if (cmd_i.pass_clr) begin
        pass_q <= '0;
      end else if (cmd_i.pass_inc) begin
        pass_q <= pass_q + 8'd1;
      end
      if (cmd_i.lad_clr) begin
        lad_q <= '0;
      end else if (cmd_i.load_wr && lad_ok) begin
        lad_q <= lad_q + LAW'(1);
      end
      rv_q     <= cmd_i.df_rd || cmd_i.ce_rd;
      cp_vld_q <= cmd_i.cp_rd;
      if (cmd_i.out_ld) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign oor = ({1'b0, col_q, 1'b0} >= width_i) || ({1'b0, row_q, 2'b0} >= height_i);

  // payload: read tags, accumulator, cell dots, output register
  always_ff @(posedge clk_i) begin
    rcell_q   <= cmd_i.ce_rd;
    rtap_q    <= cmd_i.tap;
    rok_q     <= cmd_i.ce_rd ? inb : interior;
    cp_addr_q <= addr;
    if (cmd_i.cell_ld) begin
      row_q  <= cell_row_i;
      col_q  <= cell_col_i;
      dots_q <= '0;
    end
    if (rv_q && !rcell_q) begin
      if (rtap_q == TapCentre) begin
        acc_q <= $signed({3'b0, sc_rdata}) - ((shr_x <<< 2) + (shr_x <<< 1));
      end else begin
        acc_q <= acc_q + shr_x;
      end
    end
    if (rv_q && rcell_q) begin
      dots_q[rtap_q] <= rok_q && (st_rdata > DotLevel);
    end
    if (cmd_i.out_ld) begin
      odots_q <= dots_q;
      ooor_q  <= oor;
    end
  end

  assign sts_o.xy_last   = (x_q == width_i - 8'd1) && (y_q == height_i - 8'd1);
  assign sts_o.pass_done = (pass_q == pass_count_i);
  assign sts_o.thin      = (width_i < 8'd3) || (height_i < 8'd3);
  assign sts_o.out_busy  = ov_q && !out_ready_i;

  assign out_valid_o = ov_q;
  assign out_data_o  = {2'b0, BrailleBase | {6'b0, odots_q}, odots_q};
  assign out_flag_o  = ooor_q;

endmodule

// ===== sv/dither_and_braille_cell_encoder_top.sv =====
// top level of the dither and braille cell encoder: configuration registers and
// the controller and datapath; depends on dbc_pkg, dbc_ctrl, dbc_dp, dbc_ram
//
// channel   direction  tdata (low bit up)                       tuser
// s_axis    in         pixel[7:0] cell_row[12:8] cell_col[18:13] command[1:0]
// m_axis    out        dots[7:0] codepoint[21:8]                 out_of_range[0]
// apb       in         image_width 0x0, image_height 0x4, pass_count 0x8
//
// a load writes one pixel and the controller stays idle; a read gathers its dots by
// eight serial reads of the single read port of the pixel memory; in a run, each
// pass copies the image (one pixel a cycle) then reads five scratch taps and writes
// back per pixel.
// a read result waits in the output register; a stalled output holds the next read.
// reset clears control and configuration; the memories are not cleared.
module dither_and_braille_cell_encoder_top
  import dbc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // pixel, cell_row, cell_col
  input  logic [1:0]  s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // dots, codepoint
  output logic [0:0]  m_axis_tuser,  // out_of_range
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] width_q, height_q, pass_q;
  logic [7:0] eff_w, eff_h;
  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic       in_ready;

  assign pready = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      pass_q   <= PassRst;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegWidth:  width_q  <= pwdata[7:0];
        RegHeight: height_q <= pwdata[7:0];
        RegPass:   pass_q   <= pwdata[7:0];
        default:   ;
      endcase
    end
  end

  // configuration read-back
  always_comb begin
    case (paddr[3:2])
      RegWidth:  prdata = {24'b0, width_q};
      RegHeight: prdata = {24'b0, height_q};
      RegPass:   prdata = {24'b0, pass_q};
      default:   prdata = '0;
    endcase
  end

  // sizes limited to the store dimensions
  assign eff_w = (32'(width_q) > MAX_WIDTH) ? 8'(MAX_WIDTH) : width_q;
  assign eff_h = (32'(height_q) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : height_q;

  assign s_axis_tready = in_ready;

  dbc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (in_ready),
    .in_cmd_i   (s_axis_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dbc_dp #(.MaxWidth(MAX_WIDTH), .MaxHeight(MAX_HEIGHT)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i        (cmd),
    .pixel_i      (s_axis_tdata[7:0]),
    .cell_row_i   (s_axis_tdata[12:8]),
    .cell_col_i   (s_axis_tdata[18:13]),
    .width_i      (eff_w),
    .height_i     (eff_h),
    .pass_count_i (pass_q),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_flag_o   (m_axis_tuser[0])
  );

endmodule
